>>> hw/rtl/lsgf_pkg.sv
// Shared types and constants of the scan-line ground filter.
package lsgf_pkg;

   localparam int CoordBits     = 18;
   localparam int InBits        = 17;
   localparam int PosBits       = 6;
   localparam int PointsPerLine = 64;
   localparam int CsrIdxBits    = 3;
   localparam int CsrDataBits   = 16;

   localparam logic [CsrIdxBits-1:0] CsrSensorHeight  = 3'd0;
   localparam logic [CsrIdxBits-1:0] CsrHeightOffset  = 3'd1;
   localparam logic [CsrIdxBits-1:0] CsrHeightWindow  = 3'd2;
   localparam logic [CsrIdxBits-1:0] CsrFirstUsed     = 3'd3;
   localparam logic [CsrIdxBits-1:0] CsrSlopeBase     = 3'd4;

   localparam logic [35:0] FarLimit    = 36'd1000000;
   localparam logic [35:0] FarSpan     = 36'd100000000;
   localparam logic [35:0] FarBias     = 36'd195312;
   localparam logic [18:0] FarDivisor  = 19'd390625;
   localparam logic [35:0] NearLimit   = 36'd625;
   localparam logic [35:0] NearScale   = 36'd589824;
   localparam logic [35:0] NearBias    = 36'd3125;
   localparam logic [18:0] NearDivisor = 19'd6250;

   // Reciprocals scaled by 2^37, applied to the dividend shifted right by 3 for the
   // far term and unshifted for the near term.
   localparam logic [24:0] RecipFar    = 25'd2814749;
   localparam logic [24:0] RecipNear   = 25'd21990232;

   typedef struct packed {
      logic [PosBits-1:0]       pos;
      logic signed [InBits-1:0] x;
      logic signed [InBits-1:0] y;
      logic signed [InBits-1:0] z;
      logic                     start;
      logic                     active;
      logic                     seed_ok;
   } item_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_EVAL, ST_SQR, ST_SUM, ST_PREP, ST_DIV, ST_THR,
      ST_TSQ, ST_MUL0, ST_MUL1, ST_FIN, ST_DONE
   } back_state_type;

endpackage

>>> hw/rtl/lsgf_front.sv
// Front part: accepts input beats and classifies each point.
module lsgf_front import lsgf_pkg::*; (
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [PosBits-1:0]       req_line_position,
   input  logic signed [InBits-1:0] req_coord_x,
   input  logic signed [InBits-1:0] req_coord_y,
   input  logic signed [InBits-1:0] req_coord_z,
   input  logic [11:0]              sensor_height,
   input  logic [9:0]               height_offset,
   input  logic [9:0]               height_window,
   input  logic [5:0]               first_used_index,
   input  logic                     queue_full,
   output logic                     push,
   output item_type                 item
);

   logic signed [19:0] h;
   logic [19:0]        h_abs;

   assign h = $signed({8'b0, sensor_height}) + 20'(req_coord_y) + $signed({10'b0, height_offset});
   assign h_abs = h[19] ? 20'(-h) : 20'(h);

   always_comb begin
      item.pos     = req_line_position;
      item.x       = req_coord_x;
      item.y       = req_coord_y;
      item.z       = req_coord_z;
      item.start   = (req_line_position == '0);
      item.active  = (req_line_position >= first_used_index) &&
                     ({1'b0, req_line_position} < 7'(PointsPerLine)) &&
                     !(req_coord_x == '0 && req_coord_y == '0 && req_coord_z == '0);
      item.seed_ok = (h_abs <= {10'b0, height_window});
   end

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

endmodule

>>> hw/rtl/lsgf_queue.sv
// Two-entry queue between the front and back parts.
module lsgf_queue import lsgf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output logic     full,
   output logic     not_empty,
   output item_type head
);

   item_type   mem_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_in    = push ? !wr_ff : wr_ff;
      rd_in    = pop ? !rd_ff : rd_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = mem_ff[rd_ff];

endmodule

>>> hw/rtl/lsgf_divider.sv
// Constant divider for the threshold terms: reciprocal estimate and one correction step.
module lsgf_divider import lsgf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        far_term,
   input  logic [35:0] dividend,
   input  logic [18:0] divisor,
   output logic        done,
   output logic [16:0] quotient
);

   logic [35:0] num_ff;
   logic [18:0] den_ff;
   logic        far_ff;
   logic [16:0] est_ff;
   logic [35:0] prod_ff;
   logic [16:0] quo_ff;
   logic        est_go_ff, prod_go_ff, fix_go_ff, done_ff;
   logic [31:0] num_sel;
   logic [24:0] recip_sel;
   logic [56:0] est_full;
   logic [35:0] rem;

   // The estimate is never above the true quotient and at most one below it.
   assign num_sel   = far_ff ? num_ff[34:3] : num_ff[31:0];
   assign recip_sel = far_ff ? RecipFar : RecipNear;
   assign est_full  = {25'b0, num_sel} * {32'b0, recip_sel};
   assign rem       = num_ff - prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         est_go_ff  <= 1'b0;
         prod_go_ff <= 1'b0;
         fix_go_ff  <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         est_go_ff  <= start;
         prod_go_ff <= est_go_ff;
         fix_go_ff  <= prod_go_ff;
         done_ff    <= fix_go_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         den_ff <= divisor;
         far_ff <= far_term;
      end
      if (est_go_ff) begin
         est_ff <= est_full[53:37];
      end
      if (prod_go_ff) begin
         prod_ff <= {19'b0, est_ff} * {17'b0, den_ff};
      end
      if (fix_go_ff) begin
         quo_ff <= est_ff + 17'(rem >= {17'b0, den_ff});
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> hw/rtl/lsgf_back.sv
// Back part: ground tracking, slope test sequencer and result register.
module lsgf_back import lsgf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  item_type          q_item,
   output logic              q_pop,
   input  logic [15:0]       slope_base_q16,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_obstacle_label,
   output logic              rsp_relabel_valid,
   output logic [PosBits-1:0] rsp_relabel_position
);

   back_state_type state_ff, state_in;

   item_type cur_ff;
   logic found_ff, run_ff;
   logic [PosBits-1:0] gpos_ff;
   logic signed [CoordBits-1:0] gx_ff, gy_ff, gz_ff, bx_ff, bz_ff;
   logic signed [CoordBits-1:0] dx_ff, dz_ff, dy_ff, bgx_ff, bgz_ff, bpx_ff, bpz_ff;
   logic [34:0] sdx_ff, sdz_ff, sdy_ff, sbgx_ff, sbgz_ff, sbpx_ff, sbpz_ff;
   logic [35:0] d_ff;
   logic [34:0] dy2_ff;
   logic        farther_ff;
   logic        far_ff, near_ff, clamp_ff;
   logic [16:0] t_ff;
   logic [33:0] t2_ff;
   logic [51:0] p0_ff;
   logic [69:0] rhs_ff;
   logic        res_label_ff, res_rv_ff;
   logic [PosBits-1:0] res_rp_ff;
   logic        rsp_valid_ff;
   logic        rsp_label_ff, rsp_rv_ff;
   logic [PosBits-1:0] rsp_rp_ff;

   logic        div_start, div_done;
   logic [35:0] div_dividend, e_val;
   logic [18:0] div_divisor;
   logic [16:0] div_q;
   logic        p_far, p_near, p_clamp;

   logic        load_out;
   logic        pass, moved, fin_label, fin_rv, fin_run;
   logic [PosBits-1:0] gpos_new, fin_rp;
   logic signed [6:0]  gap;
   logic signed [CoordBits-1:0] cx, cy, cz;

   assign cx = CoordBits'(cur_ff.x);
   assign cy = CoordBits'(cur_ff.y);
   assign cz = CoordBits'(cur_ff.z);

   lsgf_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .far_term (p_far),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      p_far   = (d_ff >= FarLimit);
      p_near  = (d_ff < NearLimit);
      e_val   = d_ff - FarLimit;
      p_clamp = p_far && (e_val >= FarSpan);
      if (p_far) begin
         div_dividend = (e_val << 8) + FarBias;
         div_divisor  = FarDivisor;
      end else begin
         div_dividend = (NearLimit - d_ff) * NearScale + NearBias;
         div_divisor  = NearDivisor;
      end
      div_start = (state_ff == ST_PREP) && ((p_far && !p_clamp) || p_near);
   end

   always_comb begin
      pass     = (d_ff != '0) && ({3'b0, dy2_ff, 32'b0} <= rhs_ff);
      moved    = pass && farther_ff;
      gpos_new = moved ? cur_ff.pos : gpos_ff;
      gap      = $signed({1'b0, cur_ff.pos}) - $signed({1'b0, gpos_new});
      fin_label = 1'b1;
      fin_rv    = 1'b0;
      fin_rp    = '0;
      fin_run   = run_ff;
      if (moved) begin
         if (run_ff) begin
            fin_label = 1'b0;
            fin_rv    = 1'b1;
            fin_rp    = gpos_ff;
         end else begin
            fin_run = 1'b1;
         end
      end
      if (gap > 7'sd1) begin
         fin_label = 1'b1;
         fin_run   = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: state_in = (cur_ff.active && found_ff) ? ST_SQR : ST_DONE;
         ST_SQR:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_PREP;
         ST_PREP: state_in = div_start ? ST_DIV : ST_THR;
         ST_DIV:  state_in = div_done ? ST_THR : ST_DIV;
         ST_THR:  state_in = ST_TSQ;
         ST_TSQ:  state_in = ST_MUL0;
         ST_MUL0: state_in = ST_MUL1;
         ST_MUL1: state_in = ST_FIN;
         ST_FIN:  state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         found_ff     <= 1'b0;
         run_ff       <= 1'b0;
         gpos_ff      <= '0;
         gx_ff        <= '0;
         gy_ff        <= '0;
         gz_ff        <= '0;
         bx_ff        <= '0;
         bz_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_IDLE && q_valid && q_item.start) begin
            bx_ff    <= CoordBits'(q_item.x);
            bz_ff    <= CoordBits'(q_item.z);
            found_ff <= 1'b0;
         end
         if (state_ff == ST_EVAL && cur_ff.active && !found_ff && cur_ff.seed_ok) begin
            found_ff <= 1'b1;
            gpos_ff  <= cur_ff.pos;
            gx_ff    <= cx;
            gy_ff    <= cy;
            gz_ff    <= cz;
            run_ff   <= 1'b1;
         end
         if (state_ff == ST_FIN) begin
            run_ff <= fin_run;
            if (moved) begin
               gpos_ff <= cur_ff.pos;
               gx_ff   <= cx;
               gy_ff   <= cy;
               gz_ff   <= cz;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               cur_ff <= q_item;
            end
         end
         ST_EVAL: begin
            res_label_ff <= cur_ff.active;
            res_rv_ff    <= 1'b0;
            res_rp_ff    <= '0;
            dx_ff  <= cx - gx_ff;
            dz_ff  <= cz - gz_ff;
            dy_ff  <= cy - gy_ff;
            bgx_ff <= gx_ff - bx_ff;
            bgz_ff <= gz_ff - bz_ff;
            bpx_ff <= cx - bx_ff;
            bpz_ff <= cz - bz_ff;
         end
         ST_SQR: begin
            sdx_ff  <= 35'(dx_ff * dx_ff);
            sdz_ff  <= 35'(dz_ff * dz_ff);
            sdy_ff  <= 35'(dy_ff * dy_ff);
            sbgx_ff <= 35'(bgx_ff * bgx_ff);
            sbgz_ff <= 35'(bgz_ff * bgz_ff);
            sbpx_ff <= 35'(bpx_ff * bpx_ff);
            sbpz_ff <= 35'(bpz_ff * bpz_ff);
         end
         ST_SUM: begin
            d_ff       <= {1'b0, sdx_ff} + {1'b0, sdz_ff};
            dy2_ff     <= sdy_ff;
            farther_ff <= ({1'b0, sbgx_ff} + {1'b0, sbgz_ff}) <
                          ({1'b0, sbpx_ff} + {1'b0, sbpz_ff});
         end
         ST_PREP: begin
            far_ff   <= p_far;
            near_ff  <= p_near;
            clamp_ff <= p_clamp;
         end
         ST_THR: begin
            if (far_ff) begin
               if (clamp_ff || div_q >= {1'b0, slope_base_q16}) begin
                  t_ff <= '0;
               end else begin
                  t_ff <= {1'b0, slope_base_q16} - div_q;
               end
            end else if (near_ff) begin
               t_ff <= {1'b0, slope_base_q16} + div_q;
            end else begin
               t_ff <= {1'b0, slope_base_q16};
            end
         end
         ST_TSQ:  t2_ff <= t_ff * t_ff;
         ST_MUL0: p0_ff <= t2_ff * d_ff[17:0];
         ST_MUL1: rhs_ff <= 70'(p0_ff) + (70'(t2_ff * d_ff[35:18]) << 18);
         ST_FIN: begin
            res_label_ff <= fin_label;
            res_rv_ff    <= fin_rv;
            res_rp_ff    <= fin_rp;
         end
         default: begin
         end
      endcase
      if (load_out) begin
         rsp_label_ff <= res_label_ff;
         rsp_rv_ff    <= res_rv_ff;
         rsp_rp_ff    <= res_rp_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_obstacle_label   = rsp_label_ff;
   assign rsp_relabel_valid    = rsp_rv_ff;
   assign rsp_relabel_position = rsp_rp_ff;

endmodule

>>> hw/rtl/lidar_scanline_ground_filter.sv
// Top level of the scan-line ground filter: registers, front, queue and back.
// Unmarked and seed points skip the slope test; other points take it at the base
// threshold, or at a threshold with a divided term that the divider computes first.
// Flow: the back part takes one point at a time and another only once its result
// is loaded, which a result stall can hold; the two-entry queue takes points meanwhile.
// Reset: synchronous, active high; registers take defaults, ground and run state clear.
module lidar_scanline_ground_filter import lsgf_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [PosBits-1:0]        req_line_position,
   input  logic signed [InBits-1:0]  req_coord_x,
   input  logic signed [InBits-1:0]  req_coord_y,
   input  logic signed [InBits-1:0]  req_coord_z,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_obstacle_label,
   output logic                      rsp_relabel_valid,
   output logic [PosBits-1:0]        rsp_relabel_position,
   input  logic                      csr_write_enable,
   input  logic [CsrIdxBits-1:0]     csr_index,
   input  logic [CsrDataBits-1:0]    csr_write_data
);

   logic [11:0] sensor_height_ff;
   logic [9:0]  height_offset_ff;
   logic [9:0]  height_window_ff;
   logic [5:0]  first_used_ff;
   logic [15:0] slope_base_ff;

   logic     push, pop, full, not_empty;
   item_type front_item, head_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_height_ff <= 12'd780;
         height_offset_ff <= 10'd80;
         height_window_ff <= 10'd150;
         first_used_ff    <= 6'd10;
         slope_base_ff    <= 16'd19661;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CsrSensorHeight: sensor_height_ff <= csr_write_data[11:0];
            CsrHeightOffset: height_offset_ff <= csr_write_data[9:0];
            CsrHeightWindow: height_window_ff <= csr_write_data[9:0];
            CsrFirstUsed:    first_used_ff    <= csr_write_data[5:0];
            CsrSlopeBase:    slope_base_ff    <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   lsgf_front u_front (
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_line_position (req_line_position),
      .req_coord_x       (req_coord_x),
      .req_coord_y       (req_coord_y),
      .req_coord_z       (req_coord_z),
      .sensor_height     (sensor_height_ff),
      .height_offset     (height_offset_ff),
      .height_window     (height_window_ff),
      .first_used_index  (first_used_ff),
      .queue_full        (full),
      .push              (push),
      .item              (front_item)
   );

   lsgf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .pop       (pop),
      .full      (full),
      .not_empty (not_empty),
      .head      (head_item)
   );

   lsgf_back u_back (
      .clock                (clock),
      .reset                (reset),
      .q_valid              (not_empty),
      .q_item               (head_item),
      .q_pop                (pop),
      .slope_base_q16       (slope_base_ff),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_obstacle_label   (rsp_obstacle_label),
      .rsp_relabel_valid    (rsp_relabel_valid),
      .rsp_relabel_position (rsp_relabel_position)
   );

endmodule

>>> tb/tb_lidar_scanline_ground_filter.sv
// Self-checking testbench of the scan-line ground filter with a scoreboard predictor.
`timescale 1ns / 1ps

import lsgf_pkg::*;

typedef struct packed {
   logic               label;
   logic               relabel;
   logic [PosBits-1:0] relabel_pos;
} ground_verdict_type;

class ground_scoreboard;
   longint unsigned sensor_height, height_offset, height_window, first_used, slope_base;
   bit      ground_found, run_continues;
   longint  ground_pos, ground_x, ground_y, ground_z, base_x, base_z;
   ground_verdict_type pending[$];
   int      failures, points, verdicts, relabels;

   function new();
      sensor_height = 780;
      height_offset = 80;
      height_window = 150;
      first_used    = 10;
      slope_base    = 19661;
   endfunction

   function void write_reg(logic [CsrIdxBits-1:0] idx, logic [CsrDataBits-1:0] data);
      case (idx)
         CsrSensorHeight: sensor_height = data[11:0];
         CsrHeightOffset: height_offset = data[9:0];
         CsrHeightWindow: height_window = data[9:0];
         CsrFirstUsed:    first_used    = data[5:0];
         CsrSlopeBase:    slope_base    = data[15:0];
         default: ;
      endcase
   endfunction

   function longint unsigned plane_dist(longint ax, longint az, longint bx, longint bz);
      return (ax - bx) * (ax - bx) + (az - bz) * (az - bz);
   endfunction

   function bit slope_passes(longint unsigned dy2, longint unsigned d);
      longint unsigned t, dec;
      if (d == 0) return 0;
      t = slope_base;
      if (d >= 1000000) begin
         dec = ((d - 1000000) * 65536 + 50000000) / 100000000;
         t = (dec >= t) ? 0 : t - dec;
      end else if (d < 625) begin
         t += ((625 - d) * 589824 + 3125) / 6250;
      end
      if (dy2 >= (64'd1 << 32)) return 0;
      return (dy2 << 32) <= t * t * d;
   endfunction

   function void note_point(logic [PosBits-1:0] p, logic signed [InBits-1:0] xi,
                            logic signed [InBits-1:0] yi, logic signed [InBits-1:0] zi);
      longint pos, x, y, z, dy;
      ground_verdict_type v;
      pos = p;
      x = xi;
      y = yi;
      z = zi;
      v = '0;
      points++;
      if (pos == 0) begin
         base_x = x;
         base_z = z;
         ground_found = 0;
      end
      if (pos >= first_used && pos < PointsPerLine && !(x == 0 && y == 0 && z == 0)) begin
         v.label = 1;
         if (!ground_found) begin
            longint h;
            h = longint'(sensor_height) + y + longint'(height_offset);
            if (h < 0) h = -h;
            if (h <= longint'(height_window)) begin
               ground_found = 1;
               ground_pos = pos;
               ground_x = x;
               ground_y = y;
               ground_z = z;
               run_continues = 1;
            end
         end else begin
            dy = y - ground_y;
            if (slope_passes(dy * dy, plane_dist(x, z, ground_x, ground_z)) &&
                plane_dist(ground_x, ground_z, base_x, base_z) <
                plane_dist(x, z, base_x, base_z)) begin
               if (run_continues) begin
                  v.label = 0;
                  v.relabel = 1;
                  v.relabel_pos = ground_pos[5:0];
               end else begin
                  run_continues = 1;
               end
               ground_pos = pos;
               ground_x = x;
               ground_y = y;
               ground_z = z;
            end
            if (pos - ground_pos > 1) begin
               v.label = 1;
               run_continues = 0;
            end
         end
      end
      pending.insert(pending.size(), v);
   endfunction

   function void check_result(ground_verdict_type got);
      ground_verdict_type exp_v;
      if (pending.size() == 0) begin
         $display("%0t: unexpected beat label=%0d relabel=%0d pos=%0d", $time,
                  got.label, got.relabel, got.relabel_pos);
         failures++;
         return;
      end
      exp_v = pending.pop_front();
      verdicts++;
      if (got.relabel) relabels++;
      if (got.label !== exp_v.label) begin
         $display("%0t: obstacle_label expected %0d actual %0d", $time, exp_v.label, got.label);
         failures++;
      end
      if (got.relabel !== exp_v.relabel) begin
         $display("%0t: relabel_valid expected %0d actual %0d", $time,
                  exp_v.relabel, got.relabel);
         failures++;
      end
      if (got.relabel_pos !== exp_v.relabel_pos) begin
         $display("%0t: relabel_position expected %0d actual %0d", $time,
                  exp_v.relabel_pos, got.relabel_pos);
         failures++;
      end
   endfunction
endclass

module tb_lidar_scanline_ground_filter;
   localparam int WatchdogLimit = 20000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [PosBits-1:0] req_line_position = '0;
   logic signed [InBits-1:0] req_coord_x = '0, req_coord_y = '0, req_coord_z = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic rsp_obstacle_label, rsp_relabel_valid;
   logic [PosBits-1:0] rsp_relabel_position;
   logic csr_write_enable = 0;
   logic [CsrIdxBits-1:0] csr_index = '0;
   logic [CsrDataBits-1:0] csr_write_data = '0;

   ground_scoreboard sb = new();
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int quiet_cycles = 0;
   int line_count = 0;

   always #10 clock = ~clock;

   lidar_scanline_ground_filter uut (.*);

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && !rsp_stall)
            sb.check_result({rsp_obstacle_label, rsp_relabel_valid, rsp_relabel_position});
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || csr_write_enable)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("tb_lidar_scanline_ground_filter failed");
         $finish;
      end
   end

   task automatic send_point(int pos, int x, int y, int z);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_line_position <= pos[5:0];
      req_coord_x <= x[16:0];
      req_coord_y <= y[16:0];
      req_coord_z <= z[16:0];
      do @(posedge clock); while (req_stall);
      sb.note_point(pos[5:0], x[16:0], y[16:0], z[16:0]);
   endtask

   task automatic write_reg(logic [CsrIdxBits-1:0] idx, int data);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= data[15:0];
      @(posedge clock);
      sb.write_reg(idx, data[15:0]);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic configure(int sh, int off, int win, int first, int slope);
      write_reg(CsrSensorHeight, sh);
      write_reg(CsrHeightOffset, off);
      write_reg(CsrHeightWindow, win);
      write_reg(CsrFirstUsed, first);
      write_reg(CsrSlopeBase, slope);
      csr_write_enable <= 0;
   endtask

   function automatic int rand_coord();
      return int'($urandom_range(131071)) - 65536;
   endfunction

   // A scan line along the ground with small height noise, some gaps, zeros and clutter.
   task automatic send_line();
      int n, step, x0, z0, x, y, z, level, noise, pos;
      n = $urandom_range(63, 12);
      step = ($urandom_range(3) == 0) ? $urandom_range(1500, 400) : $urandom_range(40, 2);
      x0 = $urandom_range(4000) - 2000;
      z0 = $urandom_range(4000) - 2000;
      level = -int'(sb.sensor_height + sb.height_offset);
      noise = (sb.height_window < 20) ? int'(sb.height_window) : 20;
      line_count++;
      pos = 0;
      while (pos <= n) begin
         x = x0 + pos * step;
         z = z0 + $urandom_range(4) - 2;
         y = level + $urandom_range(2 * noise) - noise;
         case ($urandom_range(19))
            0: y = y + $urandom_range(3000);
            1: begin x = 0; y = 0; z = 0; end
            2: pos = pos + $urandom_range(3, 2);
            3: begin x = rand_coord(); y = rand_coord(); z = rand_coord(); end
            default: ;
         endcase
         if (pos > 63) break;
         if (x > 65535) x = 65535;
         if (x < -65536) x = -65536;
         send_point(pos, x, y, z);
         pos++;
      end
   endtask

   task automatic run_phase(int idle_mode, int items);
      sender_idle_pct    = (idle_mode == 1) ? 84 : (idle_mode == 3) ? 9 : 0;
      receiver_stall_pct = (idle_mode == 2) ? 84 : (idle_mode == 3) ? 9 : 0;
      while (sb.points < items) begin
         if ($urandom_range(4) != 0)
            send_line();
         else
            send_point($urandom_range(63), rand_coord(), rand_coord(), rand_coord());
      end
      drain();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed points at the reset settings.
      send_point(0, 0, 0, 0);
      send_point(5, 100, -860, 0);
      send_point(10, 0, 0, 0);
      send_point(10, 500, 5000, 0);
      send_point(11, 1000, -860, 0);
      send_point(12, 1000, -860, 0);
      send_point(12, 1010, -860, 0);
      send_point(13, 1020, -858, 0);
      send_point(14, 2600, -860, 0);
      send_point(12, 2700, -860, 0);
      send_point(18, 2800, -860, 0);
      send_point(19, 65535, -65536, -65536);
      send_point(20, -65536, 65535, 65535);
      send_point(63, 3000, -860, 0);
      send_point(0, -65536, 0, 65535);
      send_point(30, -65536, -860, 65535);
      send_point(31, -65000, -860, 65535);
      send_point(32, 65535, 65535, -65536);
      drain();

      configure(4095, 1023, 1023, 63, 65535);
      send_point(0, 0, 0, 0);
      send_point(63, 10, -5118, 0);
      send_point(63, 20, -5118, 0);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: configure(780, 80, 150, 10, 19661);
            1: configure(0, 0, 0, 0, 0);
            2: configure(4095, 1023, 1023, 0, 65535);
            default: configure($urandom_range(4095), $urandom_range(1023),
                               $urandom_range(1023), $urandom_range(15), $urandom_range(65535));
         endcase
         run_phase(ph % 4, sb.points + 300);
      end
      drain();

      $display("Covered %0d points in %0d ground-like scan lines over 6 register settings.",
               sb.points, line_count);
      $display("Checked %0d result beats, %0d of them relabels.", sb.verdicts, sb.relabels);
      if (sb.failures == 0 && sb.pending.size() == 0)
         $display("tb_lidar_scanline_ground_filter passed");
      else
         $display("tb_lidar_scanline_ground_filter failed");
      $finish;
   end
endmodule

>>> filelist.f
hw/rtl/lsgf_pkg.sv
hw/rtl/lsgf_front.sv
hw/rtl/lsgf_queue.sv
hw/rtl/lsgf_divider.sv
hw/rtl/lsgf_back.sv
hw/rtl/lidar_scanline_ground_filter.sv
tb/tb_lidar_scanline_ground_filter.sv
